/* hdl/indexed_array_list_engine_unit_defines.svh */
// Assertion macros used by the indexed array-list engine RTL.
`ifndef INDEXED_ARRAY_LIST_ENGINE_UNIT_DEFINES_SVH
`define INDEXED_ARRAY_LIST_ENGINE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// The expression must never hold outside reset.
`define IALE_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion failed: condition must never hold");

// The consequent must hold in the same cycle as the antecedent.
`define IALE_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define IALE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define IALE_ASSERT_NEVER(label, expr)
`define IALE_ASSERT_IMPLIES(label, ante, cons)
`define IALE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* hdl/iale_pkg.sv */
// Shared types and constants for the indexed array-list engine.
package iale_pkg;

  // Default list capacity.
  localparam int DefCapacity = 32;

  // Fixed field widths.
  localparam int FUNC_W    = 2;
  localparam int POS_W     = 6;
  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 3;
  localparam int CNT_OUT_W = 6;

  // Request operations.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT  = 2'd0,
    FUNC_DELETE  = 2'd1,
    FUNC_COUNT   = 2'd2,
    FUNC_REPLACE = 2'd3
  } func_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADINDEX = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;    // shift up from the lower neighbor and insert at position
    logic del;    // shift down from the upper neighbor at and above position
    logic repl;   // overwrite matching in-use entries with the new value
    logic load;   // capture the match flag of each cell
    logic shift;  // move match flags one cell toward cell zero
  } cell_ctrl_t;

endpackage

/* hdl/indexed_array_list_engine_unit.sv */
// Top level of the indexed array-list engine: control, result register and cell chain.
//
//   channel   direction   handshake             words
//   request   in          in_valid / in_stall   func, position, value, new_value
//   result    out         out_valid / out_stall status, match_count, entry_count
//
// Insert and delete update the cells in the accept cycle; the output register is then loaded
// from S_FIN once no earlier result is held there by a stall.
// Count and replace latch a match flag per cell, then shift the flags into a counter one
// cell a cycle in S_SCAN before S_FIN loads the output register.
// A request word is taken whenever the control is idle, even with an earlier result still
// waiting; a stalled result holds the control. Synchronous reset empties the list.
`include "indexed_array_list_engine_unit_defines.svh"

module indexed_array_list_engine_unit #(
  parameter int CAPACITY = iale_pkg::DefCapacity
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [iale_pkg::FUNC_W-1:0]            func,
  input  logic [iale_pkg::POS_W-1:0]             position,
  input  logic signed [iale_pkg::DATA_W-1:0]     value,
  input  logic signed [iale_pkg::DATA_W-1:0]     new_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [iale_pkg::STATUS_W-1:0]          status,
  output logic [iale_pkg::CNT_OUT_W-1:0]         match_count,
  output logic [iale_pkg::CNT_OUT_W-1:0]         entry_count
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > iale_pkg::POS_W) ? CW : iale_pkg::POS_W;
  localparam int SW = $clog2(CAPACITY);
  localparam logic [CW-1:0] CAP_C     = CW'(CAPACITY);
  localparam logic [SW-1:0] LAST_STEP = SW'(CAPACITY - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t               state;
  state_t               state_next;
  logic [CW-1:0]        count;
  logic [CW-1:0]        acc;
  logic [SW-1:0]        step;
  iale_pkg::status_t    res_status;
  iale_pkg::func_t      op;
  iale_pkg::cell_ctrl_t ctrl;
  logic                 accept;
  logic                 out_load;
  logic [PW-1:0]        pos_ext;
  logic [PW-1:0]        count_ext;
  logic                 list_full;
  logic                 list_empty;
  logic                 ins_bad;
  logic                 del_bad;
  logic [CW-1:0]        acc_sum;

  logic signed [iale_pkg::DATA_W-1:0] cell_entry [CAPACITY];
  logic                               cell_flag  [CAPACITY];

  assign op        = iale_pkg::func_t'(func);
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_load  = (state == S_FIN) && (!out_valid || !out_stall);
  assign pos_ext   = PW'(position);
  assign count_ext = PW'(count);
  assign list_full  = (count == CAP_C);
  assign list_empty = (count == '0);
  assign ins_bad    = (pos_ext > count_ext);
  assign del_bad    = (pos_ext >= count_ext);
  assign acc_sum    = acc + CW'(cell_flag[0]);

  // Command to the cell chain.
  always_comb begin
    ctrl       = '0;
    ctrl.shift = (state == S_SCAN);
    if (accept) begin
      unique case (op)
        iale_pkg::FUNC_INSERT:  ctrl.ins  = !list_full && !ins_bad;
        iale_pkg::FUNC_DELETE:  ctrl.del  = !list_empty && !del_bad;
        iale_pkg::FUNC_COUNT:   ctrl.load = 1'b1;
        iale_pkg::FUNC_REPLACE: begin
          ctrl.load = 1'b1;
          ctrl.repl = 1'b1;
        end
        default: ctrl = '0;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (op == iale_pkg::FUNC_COUNT || op == iale_pkg::FUNC_REPLACE)
                       ? S_SCAN : S_FIN;
        end
      end
      S_SCAN: begin
        if (step == LAST_STEP) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Number of entries in use.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.ins) begin
      count <= count + 1'b1;
    end else if (ctrl.del) begin
      count <= count - 1'b1;
    end
  end

  // Match accumulation and pending result status.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      step       <= '0;
      res_status <= iale_pkg::ST_OK;
    end else if (accept) begin
      acc  <= '0;
      step <= '0;
      unique case (op)
        iale_pkg::FUNC_INSERT: begin
          priority if (list_full) res_status <= iale_pkg::ST_FULL;
          else if (ins_bad)       res_status <= iale_pkg::ST_BADINDEX;
          else                    res_status <= iale_pkg::ST_OK;
        end
        iale_pkg::FUNC_DELETE: begin
          priority if (list_empty) res_status <= iale_pkg::ST_EMPTY;
          else if (del_bad)        res_status <= iale_pkg::ST_BADINDEX;
          else                     res_status <= iale_pkg::ST_OK;
        end
        default: res_status <= iale_pkg::ST_OK;
      endcase
    end else if (state == S_SCAN) begin
      acc  <= acc_sum;
      step <= step + 1'b1;
      if (step == LAST_STEP) begin
        res_status <= (acc_sum == '0) ? iale_pkg::ST_NOTFOUND : iale_pkg::ST_OK;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status      <= res_status;
      match_count <= iale_pkg::CNT_OUT_W'(acc);
      entry_count <= iale_pkg::CNT_OUT_W'(count);
    end
  end

  // Cell chain: each cell sees its two neighbors.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [iale_pkg::DATA_W-1:0] left_entry;
    logic signed [iale_pkg::DATA_W-1:0] right_entry;
    logic                               right_flag;

    if (k == 0) begin : g_first
      assign left_entry = value;
    end else begin : g_inner_l
      assign left_entry = cell_entry[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign right_entry = value;
      assign right_flag  = 1'b0;
    end else begin : g_inner_r
      assign right_entry = cell_entry[k+1];
      assign right_flag  = cell_flag[k+1];
    end

    iale_cell #(
      .INDEX (k),
      .CW    (CW),
      .PW    (PW)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .pos         (pos_ext),
      .count       (count),
      .value       (value),
      .new_value   (new_value),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .right_flag  (right_flag),
      .entry       (cell_entry[k]),
      .flag        (cell_flag[k])
    );
  end

  // Checks.
  `IALE_ASSERT_NEVER(a_count_bound, count > CAP_C)
  `IALE_ASSERT_NEXT(a_insert_grows, ctrl.ins, count == $past(count) + 1'b1)
  `IALE_ASSERT_NEXT(a_delete_shrinks, ctrl.del, count == $past(count) - 1'b1)
  `IALE_ASSERT_NEXT(a_load_shows, out_load, out_valid && (state == S_IDLE))
  `IALE_ASSERT_IMPLIES(a_scan_busy, state == S_SCAN, in_stall && !ctrl.ins && !ctrl.del)

endmodule

/* hdl/iale_cell.sv */
// One cell of the list chain: holds one entry and one match flag.
module iale_cell #(
  parameter int INDEX = 0,
  parameter int CW    = 6,
  parameter int PW    = 6
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  iale_pkg::cell_ctrl_t                   ctrl,
  input  logic [PW-1:0]                          pos,
  input  logic [CW-1:0]                          count,
  input  logic signed [iale_pkg::DATA_W-1:0]     value,
  input  logic signed [iale_pkg::DATA_W-1:0]     new_value,
  input  logic signed [iale_pkg::DATA_W-1:0]     left_entry,
  input  logic signed [iale_pkg::DATA_W-1:0]     right_entry,
  input  logic                                   right_flag,
  output logic signed [iale_pkg::DATA_W-1:0]     entry,
  output logic                                   flag
);

  localparam logic [PW-1:0] IDX_P = PW'(INDEX);
  localparam logic [CW-1:0] IDX_C = CW'(INDEX);

  logic in_use;
  logic match;

  // An entry takes part in a search only while it is inside the list.
  assign in_use = (IDX_C < count);
  assign match  = in_use && (entry == value);

  // Entry update: shifts come from the neighbors, the insert word from the request.
  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (IDX_P > pos) begin
        entry <= left_entry;
      end else if (IDX_P == pos) begin
        entry <= value;
      end
    end else if (ctrl.del) begin
      if (IDX_P >= pos) begin
        entry <= right_entry;
      end
    end else if (ctrl.repl && match) begin
      entry <= new_value;
    end
  end

  // Match flag: captured on a search, then handed down the chain.
  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
    end else if (ctrl.load) begin
      flag <= match;
    end else if (ctrl.shift) begin
      flag <= right_flag;
    end
  end

endmodule
